@@ design/rcfd_pkg.sv @@
`default_nettype none
package rcfd_pkg;

  localparam int unsigned MaxChannels = 16;

  localparam logic [1:0] ModeCrsf = 2'd0;
  localparam logic [1:0] ModeSbus = 2'd1;
  localparam logic [1:0] ModeIbus = 2'd2;

  localparam logic [7:0] CrsfSyncA   = 8'hC8;
  localparam logic [7:0] CrsfSyncB   = 8'hEE;
  localparam logic [7:0] CrsfSyncC   = 8'hEC;
  localparam logic [7:0] CrsfTypeRc  = 8'h16;
  localparam logic [7:0] CrsfPoly    = 8'hD5;
  localparam logic [7:0] SbusHeader  = 8'h0F;
  localparam logic [7:0] IbusHeadA   = 8'h20;
  localparam logic [7:0] IbusHeadB   = 8'h40;

  typedef struct packed {
    logic       ibus;
    logic       failsafe;
    logic [4:0] base;
  } unpack_cmd_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc_in, logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrsfPoly) : (c << 1);
    end
    return c;
  endfunction

  // 1500 + trunc((raw - 992) * 5 / 8), clamped to 880..2120
  function automatic logic [15:0] raw_to_us(logic [10:0] raw);
    logic signed [15:0] d;
    logic signed [15:0] m;
    logic signed [15:0] q;
    logic signed [15:0] us;
    d = $signed({5'd0, raw}) - 16'sd992;
    m = d * 16'sd5;
    q = (m < 0) ? ((m + 16'sd7) >>> 3) : (m >>> 3);
    us = q + 16'sd1500;
    if (us < 16'sd880) us = 16'sd880;
    if (us > 16'sd2120) us = 16'sd2120;
    return 16'(us);
  endfunction

endpackage
`default_nettype wire

@@ design/rcfd_frame_store.sv @@
`default_nettype none
module rcfd_frame_store #(
  parameter int unsigned FrameBytes = 64,
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0]            mem [FrameBytes];
  logic [FrameBytes-1:0] valid_q;
  logic [7:0]            rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) valid_q[waddr_i] <= 1'b1;
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'd0;

endmodule
`default_nettype wire

@@ design/rcfd_unpack.sv @@
`default_nettype none
module rcfd_unpack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire rcfd_pkg::unpack_cmd_t cmd_i,
  output logic [4:0]                rd_addr_o,
  input  wire logic [7:0]           rd_data_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [3:0]                chan_index_o,
  output logic [15:0]               chan_us_o,
  output logic [4:0]                chan_count_o,
  output logic                      failsafe_flag_o,
  output logic                      last_channel_o
);
  import rcfd_pkg::*;

  typedef enum logic [1:0] {StIdle, StFetch, StLoad, StEmit} state_e;

  state_e      state_q;
  unpack_cmd_t cmd_q;
  logic [4:0]  addr_q;
  logic [23:0] acc_q;
  logic [4:0]  have_q;
  logic [3:0]  ch_q;
  logic [4:0]  need;
  logic [4:0]  have_after;
  logic [4:0]  have_load;
  logic [3:0]  last_ch;
  logic        out_free;

  assign need       = cmd_q.ibus ? 5'd16 : 5'd11;
  assign last_ch    = cmd_q.ibus ? 4'd13 : 4'd15;
  assign have_after = have_q - need;
  assign have_load  = have_q + 5'd8;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign rd_addr_o  = addr_q;
  assign busy_o     = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      cmd_q           <= '0;
      addr_q          <= '0;
      acc_q           <= '0;
      have_q          <= '0;
      ch_q            <= '0;
      out_valid_o     <= 1'b0;
      chan_index_o    <= '0;
      chan_us_o       <= '0;
      chan_count_o    <= '0;
      failsafe_flag_o <= 1'b0;
      last_channel_o  <= 1'b0;
    end else begin
      // in the emit state the output register is either reloaded or held
      if (out_valid_o && !out_stall_i && (state_q != StEmit)) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            addr_q  <= cmd_i.base;
            acc_q   <= '0;
            have_q  <= '0;
            ch_q    <= '0;
            state_q <= StFetch;
          end
        end
        StFetch: state_q <= StLoad;
        StLoad: begin
          acc_q   <= acc_q | (24'(rd_data_i) << have_q);
          have_q  <= have_load;
          addr_q  <= addr_q + 5'd1;
          state_q <= (have_load >= need) ? StEmit : StFetch;
        end
        StEmit: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            chan_index_o    <= ch_q;
            chan_us_o       <= cmd_q.ibus ? acc_q[15:0] : raw_to_us(acc_q[10:0]);
            chan_count_o    <= cmd_q.ibus ? 5'd14 : 5'd16;
            failsafe_flag_o <= cmd_q.failsafe;
            last_channel_o  <= (ch_q == last_ch);
            acc_q           <= acc_q >> need;
            have_q          <= have_after;
            ch_q            <= ch_q + 4'd1;
            if (ch_q == last_ch) state_q <= StIdle;
            else if (have_after < need) state_q <= StFetch;
            else state_q <= StEmit;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/rc_serial_frame_decoder_unit.sv @@
`default_nettype none
// channel   | handshake            | payload
// config    | cfg_we_i             | cfg_wdata_i (protocol_mode)
// input     | in_valid_i/in_stall_o| rx_byte_i
// output    | out_valid_o/out_stall_i | chan_index_o chan_us_o chan_count_o
//           |                      |   failsafe_flag_o last_channel_o
// a byte takes one cycle unless the input is stalled; crc and checksum are kept running
// as bytes arrive. a valid frame then unpacks from the frame memory channel by channel
// (one read port, each byte read passes a fetch and a load state); input is stalled
// meanwhile. output stall holds the unpacker.
// frame memory and parser state clear at reset; a config write clears the parser position
module rc_serial_frame_decoder_unit #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       chan_index_o,
  output logic [15:0]      chan_us_o,
  output logic [4:0]       chan_count_o,
  output logic             failsafe_flag_o,
  output logic             last_channel_o
);
  import rcfd_pkg::*;

  localparam int unsigned AddrW = $clog2(FRAME_BYTES);
  localparam logic [6:0] FrameLimit = 7'(FRAME_BYTES);

  logic [1:0]  mode_q;
  logic [6:0]  pos_q, pos_d;
  logic [5:0]  len_q, len_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic        fs_q, fs_d;
  logic [7:0]  lo_q, lo_d;
  logic        we;
  logic        start;
  unpack_cmd_t cmd;
  logic        busy;
  logic [4:0]  rd_addr;
  logic [7:0]  rd_data;
  logic        accept;
  logic [6:0]  total;
  logic [7:0]  b;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign b          = rx_byte_i;
  assign total      = 7'd2 + {1'b0, len_q};

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    crc_d  = crc_q;
    sum_d  = sum_q;
    type_d = type_q;
    fs_d   = fs_q;
    lo_d   = lo_q;
    we     = 1'b0;
    start  = 1'b0;
    cmd    = '0;
    if (accept) begin
      unique case (mode_q)
        ModeCrsf: begin
          cmd.base = 5'd3;
          if (pos_q == 7'd0) begin
            if (b == CrsfSyncA || b == CrsfSyncB || b == CrsfSyncC) begin
              we = 1'b1; pos_d = 7'd1;
            end
          end else if (pos_q == 7'd1) begin
            if (b < 8'd2 || b > 8'd62) begin
              pos_d = 7'd0;
            end else begin
              len_d = b[5:0]; we = 1'b1; pos_d = 7'd2; crc_d = 8'd0;
            end
          end else if (pos_q >= total || total > FrameLimit) begin
            pos_d = 7'd0;
          end else begin
            we    = 1'b1;
            pos_d = pos_q + 7'd1;
            if (pos_q == 7'd2) type_d = b;
            if (pos_q + 7'd1 != total) begin
              crc_d = crc8_step(crc_q, b);
            end else begin
              pos_d = 7'd0;
              start = (crc_q == b) && (type_q == CrsfTypeRc);
            end
          end
        end
        ModeSbus: begin
          cmd.base     = 5'd1;
          cmd.failsafe = fs_q;
          if (pos_q == 7'd0) begin
            if (b == SbusHeader) begin
              we = 1'b1; pos_d = 7'd1;
            end
          end else if (pos_q >= 7'd25) begin
            pos_d = 7'd0;
          end else begin
            we    = 1'b1;
            pos_d = pos_q + 7'd1;
            if (pos_q == 7'd23) fs_d = b[3];
            if (pos_q == 7'd24) begin
              pos_d = 7'd0;
              start = (b == 8'h00) || (b == 8'h04) || (b == 8'h14) || (b == 8'h24)
                   || (b == 8'h34) || (b == 8'h08);
            end
          end
        end
        ModeIbus: begin
          cmd.base = 5'd2;
          cmd.ibus = 1'b1;
          if (pos_q == 7'd0) begin
            if (b == IbusHeadA) begin
              we = 1'b1; pos_d = 7'd1; sum_d = {8'd0, b};
            end
          end else if (pos_q == 7'd1) begin
            if (b == IbusHeadB) begin
              we = 1'b1; pos_d = 7'd2; sum_d = sum_q + {8'd0, b};
            end else begin
              pos_d = 7'd0;
            end
          end else if (pos_q >= 7'd32) begin
            pos_d = 7'd0;
          end else begin
            we    = 1'b1;
            pos_d = pos_q + 7'd1;
            if (pos_q < 7'd30) sum_d = sum_q + {8'd0, b};
            if (pos_q == 7'd30) lo_d = b;
            if (pos_q == 7'd31) begin
              pos_d = 7'd0;
              start = ((16'hFFFF - sum_q) == {b, lo_q});
            end
          end
        end
        default: ;
      endcase
    end
    if (we && pos_q >= FrameLimit) we = 1'b0;
    if (cfg_we_i) begin
      pos_d = 7'd0;
      len_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCrsf;
      pos_q  <= '0;
      len_q  <= '0;
      crc_q  <= '0;
      sum_q  <= '0;
      type_q <= '0;
      fs_q   <= 1'b0;
      lo_q   <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      pos_q  <= pos_d;
      len_q  <= len_d;
      crc_q  <= crc_d;
      sum_q  <= sum_d;
      type_q <= type_d;
      fs_q   <= fs_d;
      lo_q   <= lo_d;
    end
  end

  rcfd_frame_store #(
    .FrameBytes(FRAME_BYTES),
    .AddrW     (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(pos_q[AddrW-1:0]),
    .wdata_i(b),
    .raddr_i(AddrW'(rd_addr)),
    .rdata_o(rd_data)
  );

  rcfd_unpack u_unpack (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chan_index_o   (chan_index_o),
    .chan_us_o      (chan_us_o),
    .chan_count_o   (chan_count_o),
    .failsafe_flag_o(failsafe_flag_o),
    .last_channel_o (last_channel_o)
  );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rcfd_pkg::*;

  typedef struct {
    logic [3:0]  idx;
    logic [15:0] us;
    logic [4:0]  cnt;
    logic        fs;
    logic        is_last;
  } chan_result_t;

  class rc_frame_scoreboard;
    logic [7:0]   store [64];
    int unsigned  pos;
    int unsigned  dlen;
    logic [1:0]   mode;
    chan_result_t expected_chans [$];
    int unsigned  mismatches;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      pos = 0;
      dlen = 0;
      mode = ModeCrsf;
      mismatches = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
      pos = 0;
      dlen = 0;
    endfunction

    function logic [7:0] rd(int unsigned i);
      return (i < 64) ? store[i] : 8'h00;
    endfunction

    function void put(logic [7:0] b);
      if (pos < 64) store[pos] = b;
      pos = (pos + 1) & 32'h7F;
    endfunction

    function logic [15:0] to_us(int raw);
      int v;
      v = ((raw - 992) * 5) / 8 + 1500;
      if (v < 880) v = 880;
      if (v > 2120) v = 2120;
      return 16'(v);
    endfunction

    function void push_frame(logic [15:0] vals [16], int unsigned n, logic fs);
      chan_result_t r;
      for (int unsigned i = 0; i < n; i++) begin
        r.idx = 4'(i);
        r.us = vals[i];
        r.cnt = 5'(n);
        r.fs = fs;
        r.is_last = (i + 1 == n);
        expected_chans.push_back(r);
      end
    endfunction

    function void unpack11(int unsigned base, output logic [15:0] vals [16]);
      int unsigned acc, have, bi;
      acc = 0;
      have = 0;
      bi = base;
      for (int ch = 0; ch < 16; ch++) begin
        while (have < 11) begin
          acc |= int'(rd(bi)) << have;
          bi++;
          have += 8;
        end
        vals[ch] = to_us(int'(acc & 32'h7FF));
        acc >>= 11;
        have -= 11;
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [15:0] vals [16];
      logic [7:0]  crc, f, flg;
      logic [15:0] sum, chk, got;
      int unsigned total;
      case (mode)
        ModeCrsf: begin
          if (pos == 0) begin
            if (b == CrsfSyncA || b == CrsfSyncB || b == CrsfSyncC) put(b);
          end else if (pos == 1) begin
            if (b < 2 || b > 62) pos = 0;
            else begin
              dlen = b & 8'h3F;
              put(b);
            end
          end else begin
            total = 2 + dlen;
            if (pos >= total || total > 64) pos = 0;
            else begin
              put(b);
              if (pos == total) begin
                pos = 0;
                crc = 8'h00;
                for (int unsigned i = 0; i < dlen - 1; i++) begin
                  crc ^= rd(2 + i);
                  for (int k = 0; k < 8; k++) crc = crc[7] ? ((crc << 1) ^ 8'hD5) : (crc << 1);
                end
                if (crc == rd(total - 1) && rd(2) == CrsfTypeRc) begin
                  unpack11(3, vals);
                  push_frame(vals, 16, 1'b0);
                end
              end
            end
          end
        end
        ModeSbus: begin
          if (pos == 0) begin
            if (b == SbusHeader) put(b);
          end else if (pos >= 25) pos = 0;
          else begin
            put(b);
            if (pos == 25) begin
              pos = 0;
              f = rd(24);
              if (f == 8'h00 || f == 8'h04 || f == 8'h14 || f == 8'h24 || f == 8'h34 ||
                  f == 8'h08) begin
                unpack11(1, vals);
                flg = rd(23);
                push_frame(vals, 16, flg[3]);
              end
            end
          end
        end
        ModeIbus: begin
          if (pos == 0) begin
            if (b == IbusHeadA) put(b);
          end else if (pos == 1) begin
            if (b == IbusHeadB) put(b);
            else pos = 0;
          end else if (pos >= 32) pos = 0;
          else begin
            put(b);
            if (pos == 32) begin
              pos = 0;
              sum = 16'h0000;
              for (int unsigned i = 0; i < 30; i++) sum = sum + 16'(rd(i));
              chk = 16'hFFFF - sum;
              got = {rd(31), rd(30)};
              if (chk == got) begin
                for (int unsigned i = 0; i < 14; i++) vals[i] = {rd(3 + 2 * i), rd(2 + 2 * i)};
                push_frame(vals, 14, 1'b0);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_channel(chan_result_t got);
      chan_result_t exp_r;
      if (expected_chans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected channel result idx=%0d us=%0d", got.idx, got.us);
        return;
      end
      exp_r = expected_chans.pop_front();
      if (got.idx !== exp_r.idx || got.us !== exp_r.us || got.cnt !== exp_r.cnt ||
          got.fs !== exp_r.fs || got.is_last !== exp_r.is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx=%0d us=%0d cnt=%0d fs=%0d last=%0d, got idx=%0d us=%0d cnt=%0d fs=%0d last=%0d",
                   exp_r.idx, exp_r.us, exp_r.cnt, exp_r.fs, exp_r.is_last,
                   got.idx, got.us, got.cnt, got.fs, got.is_last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = 2'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  chan_index_o;
  logic [15:0] chan_us_o;
  logic [4:0]  chan_count_o;
  logic        failsafe_flag_o;
  logic        last_channel_o;

  rc_serial_frame_decoder_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i(rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .chan_index_o(chan_index_o),
    .chan_us_o(chan_us_o),
    .chan_count_o(chan_count_o),
    .failsafe_flag_o(failsafe_flag_o),
    .last_channel_o(last_channel_o)
  );

  always #1 clk_i = ~clk_i;

  rc_frame_scoreboard sb = new();
  logic       quiet = 1'b0;
  logic       long_hold_req = 1'b0;
  int         cycles = 0;
  logic [7:0] frm [64];

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // channel monitor
  always @(posedge clk_i) begin
    chan_result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.idx = chan_index_o;
      r.us = chan_us_o;
      r.cnt = chan_count_o;
      r.fs = failsafe_flag_o;
      r.is_last = last_channel_o;
      sb.check_channel(r);
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_rx_byte(b);
  endtask

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_byte(frm[i]);
  endtask

  task automatic set_mode(logic [1:0] m);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_chans.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_mode(m);
  endtask

  // fill: 0 all zero, 1 all ones, otherwise random
  function automatic logic [7:0] fill_byte(int fill);
    return (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
  endfunction

  task automatic crsf_frame(logic [7:0] sync, int len, logic [7:0] typ, int fill, bit bad);
    logic [7:0] crc;
    frm[0] = sync;
    frm[1] = 8'(len);
    frm[2] = typ;
    for (int i = 3; i <= len; i++) frm[i] = fill_byte(fill);
    crc = 8'h00;
    for (int i = 2; i <= len; i++) begin
      crc ^= frm[i];
      for (int k = 0; k < 8; k++) crc = crc[7] ? ((crc << 1) ^ 8'hD5) : (crc << 1);
    end
    frm[len + 1] = crc ^ {7'd0, bad};
    send_frame(len + 2);
  endtask

  task automatic sbus_frame(logic [7:0] flags, logic [7:0] footer, int fill);
    frm[0] = SbusHeader;
    for (int i = 1; i <= 22; i++) frm[i] = fill_byte(fill);
    frm[23] = flags;
    frm[24] = footer;
    send_frame(25);
  endtask

  task automatic ibus_frame(int fill, bit bad);
    logic [15:0] sum;
    frm[0] = IbusHeadA;
    frm[1] = IbusHeadB;
    for (int i = 2; i < 30; i++) frm[i] = fill_byte(fill);
    sum = 16'h0000;
    for (int i = 0; i < 30; i++) sum = sum + 16'(frm[i]);
    sum = 16'hFFFF - sum;
    frm[30] = sum[7:0] ^ {7'd0, bad};
    frm[31] = sum[15:8];
    send_frame(32);
  endtask

  function automatic logic [7:0] pick_footer();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h04;
      2: return 8'h14;
      3: return 8'h24;
      4: return 8'h34;
      default: return 8'h08;
    endcase
  endfunction

  task automatic random_phase(logic [1:0] m, int frames);
    logic [7:0] sync;
    int r;
    set_mode(m);
    for (int f = 0; f < frames; f++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        case (m)
          ModeCrsf: begin
            case ($urandom_range(0, 2))
              0: sync = CrsfSyncA;
              1: sync = CrsfSyncB;
              default: sync = CrsfSyncC;
            endcase
            crsf_frame(sync, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 62) : 24,
                       ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CrsfTypeRc,
                       2, r == 1);
          end
          ModeSbus: sbus_frame(8'($urandom_range(0, 255)),
                               (r == 1) ? 8'($urandom_range(0, 255)) : pick_footer(), 2);
          default: ibus_frame(2, r == 1);
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // crsf: zero fill under a long output hold-off, short, bad crc, wrong type, bad lengths
    set_mode(ModeCrsf);
    send_byte(8'h00);
    long_hold_req = 1'b1;
    crsf_frame(CrsfSyncA, 24, CrsfTypeRc, 0, 0);
    crsf_frame(CrsfSyncB, 2, CrsfTypeRc, 2, 0);
    crsf_frame(CrsfSyncC, 5, CrsfTypeRc, 2, 1);
    crsf_frame(CrsfSyncA, 3, 8'h14, 2, 0);
    send_byte(CrsfSyncA);
    send_byte(8'd1);
    send_byte(CrsfSyncB);
    send_byte(8'd63);
    send_byte(8'hFF);

    // sbus: all ones with failsafe set
    set_mode(ModeSbus);
    sbus_frame(8'hFF, 8'h04, 1);

    // ibus: broken second header byte, then a good frame
    set_mode(ModeIbus);
    send_byte(IbusHeadA);
    send_byte(8'h41);
    ibus_frame(2, 0);

    quiet = 1'b1;
    random_phase(ModeCrsf, 1);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_chans.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_chans.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
